/* src/lgrs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgrs_pkg
// Shared widths, register indexes, rule codes and the lane result type of the
// life generation row step block.
// ----------------------------------------------------------------------------
package lgrs_pkg;

  // Payload widths of the channels
  localparam int ROW_W     = 64;
  localparam int CNT_W     = 7;
  localparam int ROW_IDX_W = 10;

  // Configuration port
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RULE_MODE  = 1'd1;
  localparam logic [CFG_W-1:0]     GRID_WIDTH_RESET = 7'd64;

  // Rule codes
  localparam logic RULE_STANDARD = 1'b0;
  localparam logic RULE_ALT      = 1'b1;

  // Neighbour counts that matter to the rules
  localparam int NBR_W      = 4;
  localparam int BIRTH_N    = 3;
  localparam int SURVIVE_LO = 2;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH = 64;
  localparam int DEF_MAX_ROWS  = 1024;

  // Population count tree: groups of eight bits
  localparam int GRP_W     = 8;
  localparam int NGRP      = ROW_W / GRP_W;
  localparam int GRP_CNT_W = 4;

  // One resolved row on its way to the merge stage
  typedef struct packed {
    logic [ROW_W-1:0]     next_cells;
    logic [ROW_W-1:0]     changed_mask;
    logic [ROW_IDX_W-1:0] row_index;
    logic                 last_row;
  } res_t;

endpackage
`default_nettype wire

/* src/lgrs_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgrs_if
// Valid/ready channels: the row input channel and the result channel.
// ----------------------------------------------------------------------------
interface lgrs_in_if;
  logic                       valid;
  logic                       ready;
  logic [lgrs_pkg::ROW_W-1:0] row_cells;
  logic                       end_of_grid;

  modport source (output valid, output row_cells, output end_of_grid, input ready);
  modport sink   (input valid, input row_cells, input end_of_grid, output ready);
endinterface

interface lgrs_out_if;
  logic                           valid;
  logic                           ready;
  logic [lgrs_pkg::ROW_W-1:0]     next_cells;
  logic [lgrs_pkg::ROW_W-1:0]     changed_mask;
  logic [lgrs_pkg::CNT_W-1:0]     changed_count;
  logic [lgrs_pkg::ROW_IDX_W-1:0] row_index;
  logic                           last_row;

  modport source (output valid, output next_cells, output changed_mask,
                  output changed_count, output row_index, output last_row,
                  input ready);
  modport sink   (input valid, input next_cells, input changed_mask,
                  input changed_count, input row_index, input last_row,
                  output ready);
endinterface
`default_nettype wire

/* src/lgrs_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgrs_lane
// One cell: count the eight neighbours and apply the selected rule.
// ----------------------------------------------------------------------------
module lgrs_lane (
  input  wire logic [2:0] up_i,
  input  wire logic [1:0] side_i,
  input  wire logic [2:0] down_i,
  input  wire logic       alive_i,
  input  wire logic       rule_i,
  output logic            live_o
);

  logic [lgrs_pkg::NBR_W-1:0] cnt;

  // Sum the neighbours
  always_comb begin
    cnt = lgrs_pkg::NBR_W'(up_i[0]) + lgrs_pkg::NBR_W'(up_i[1])
        + lgrs_pkg::NBR_W'(up_i[2]) + lgrs_pkg::NBR_W'(side_i[0])
        + lgrs_pkg::NBR_W'(side_i[1]) + lgrs_pkg::NBR_W'(down_i[0])
        + lgrs_pkg::NBR_W'(down_i[1]) + lgrs_pkg::NBR_W'(down_i[2]);
  end

  // Pick the next state
  always_comb begin
    unique case (rule_i)
      lgrs_pkg::RULE_ALT: begin
        live_o = alive_i || (cnt == lgrs_pkg::NBR_W'(lgrs_pkg::SURVIVE_LO));
      end
      default: begin
        if (alive_i) begin
          live_o = (cnt == lgrs_pkg::NBR_W'(lgrs_pkg::SURVIVE_LO))
                || (cnt == lgrs_pkg::NBR_W'(lgrs_pkg::BIRTH_N));
        end else begin
          live_o = (cnt == lgrs_pkg::NBR_W'(lgrs_pkg::BIRTH_N));
        end
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/lgrs_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgrs_merge
// Merge the lane results: count changed cells in a two-level registered tree
// and hold the finished result in the output register.
// ----------------------------------------------------------------------------
module lgrs_merge (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           res_valid_i,
  output logic                res_ready_o,
  input  wire lgrs_pkg::res_t res_i,
  lgrs_out_if.source          out_ch
);

  localparam int NGRP = lgrs_pkg::NGRP;
  localparam int GW   = lgrs_pkg::GRP_W;
  localparam int GCW  = lgrs_pkg::GRP_CNT_W;
  localparam int CW   = lgrs_pkg::CNT_W;

  logic                      a_v_r;
  lgrs_pkg::res_t            a_res_r;
  logic [NGRP-1:0][GCW-1:0]  a_grp_r;
  logic [NGRP-1:0][GCW-1:0]  grp_nxt;
  logic                      b_v_r;
  lgrs_pkg::res_t            b_res_r;
  logic [CW-1:0]             b_cnt_r;
  logic [CW-1:0]             cnt_nxt;
  logic                      b_ready;
  logic                      a_ready;

  // Stall chain back from the output register
  assign b_ready     = !b_v_r || out_ch.ready;
  assign a_ready     = !a_v_r || b_ready;
  assign res_ready_o = a_ready;

  // Count each group of eight changed bits
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int b = 0; b < GW; b++) begin
        grp_nxt[g] = grp_nxt[g] + GCW'(res_i.changed_mask[g*GW+b]);
      end
    end
  end

  // Add up the group counts
  always_comb begin
    cnt_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      cnt_nxt = cnt_nxt + CW'(a_grp_r[g]);
    end
  end

  // Advance the group-count stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_ready) begin
      a_v_r <= res_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && res_valid_i) begin
      a_res_r <= res_i;
      a_grp_r <= grp_nxt;
    end
  end

  // Advance the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_ready) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_v_r) begin
      b_res_r <= a_res_r;
      b_cnt_r <= cnt_nxt;
    end
  end

  assign out_ch.valid         = b_v_r;
  assign out_ch.next_cells    = b_res_r.next_cells;
  assign out_ch.changed_mask  = b_res_r.changed_mask;
  assign out_ch.changed_count = b_cnt_r;
  assign out_ch.row_index     = b_res_r.row_index;
  assign out_ch.last_row      = b_res_r.last_row;

endmodule
`default_nettype wire

/* src/life_generation_row_step_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// life_generation_row_step_top
// One generation of a two-state automaton over a grid streamed row by row.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one grid row per transfer (row_cells, column 0 in bit 0)
//   and end_of_grid on the last row. out_ch carries one result per row:
//   next generation, changed mask, changed count, row index, last_row.
//   A row's result follows the transfer of the row below it; the row
//   flagged end_of_grid is resolved in the same transfer against a dead
//   row, so that transfer yields two results when a row is already held.
//   A result passes through the job register, the count stage and the
//   output register before it is offered on out_ch. Throughput: one row
//   per cycle while out_ch does not stall, set by the MAX_WIDTH cell lanes
//   that resolve a whole row at once. After an end_of_grid row with a row
//   already held, in_ch.ready stays low until its second result has taken
//   the job register, because that result shares the lanes.
//   cfg_we/cfg_index/cfg_wdata write grid_width and rule_mode; write only
//   while no results are outstanding.
//   Reset clears all held rows and the row counter and restores
//   grid_width 64 and the standard rule; no clearing pass is needed.
//   When out_ch stalls, results hold in the pipeline and in_ch.ready drops
//   once the pipeline is full.
// ----------------------------------------------------------------------------
module life_generation_row_step_top #(
  parameter int MAX_WIDTH = lgrs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_ROWS  = lgrs_pkg::DEF_MAX_ROWS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [lgrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lgrs_pkg::CFG_W-1:0]     cfg_wdata,
  lgrs_in_if.sink                             in_ch,
  lgrs_out_if.source                          out_ch
);

  localparam int W  = MAX_WIDTH;
  localparam int IW = lgrs_pkg::ROW_IDX_W;
  localparam int CFW = lgrs_pkg::CFG_W;
  localparam logic [IW-1:0] IDX_MAX = IW'(MAX_ROWS - 1);

  typedef struct packed {
    logic [W-1:0]  up;
    logic [W-1:0]  mid;
    logic [W-1:0]  down;
    logic [IW-1:0] idx;
    logic          last;
  } job_t;

  logic [CFW-1:0] width_r;
  logic           rule_r;
  logic [CFW-1:0] w_eff;
  logic [W-1:0]   col_mask;

  logic [W-1:0]   above_r;
  logic [W-1:0]   held_r;
  logic           held_v_r;
  logic [IW-1:0]  cnt_r;
  logic [IW-1:0]  cnt_inc;

  logic [W-1:0]   in_row;
  logic           in_xfer;
  job_t           job1;
  job_t           job2;
  job_t           job_r;
  logic           job_v_r;
  job_t           pend_r;
  logic           pend_v_r;
  logic           job_adv;
  logic           res_ready;

  logic [W+1:0]   up_p;
  logic [W+1:0]   mid_p;
  logic [W+1:0]   down_p;
  logic [W-1:0]   live;
  logic [W-1:0]   next_row;
  lgrs_pkg::res_t res;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= lgrs_pkg::GRID_WIDTH_RESET;
      rule_r  <= lgrs_pkg::RULE_STANDARD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lgrs_pkg::REG_GRID_WIDTH: width_r <= cfg_wdata;
        lgrs_pkg::REG_RULE_MODE:  rule_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Columns in use: clamp the width, one compare per lane
  always_comb begin
    w_eff = (width_r > CFW'(W)) ? CFW'(W) : width_r;
    for (int c = 0; c < W; c++) begin
      col_mask[c] = (CFW'(c) < w_eff);
    end
  end

  assign in_row  = in_ch.row_cells[W-1:0] & col_mask;
  assign cnt_inc = (cnt_r < IDX_MAX) ? cnt_r + IW'(1) : cnt_r;

  // Jobs a transfer can raise: the held row, and the flushed last row
  always_comb begin
    job1.up   = above_r & col_mask;
    job1.mid  = held_r & col_mask;
    job1.down = in_row;
    job1.idx  = cnt_r;
    job1.last = 1'b0;
    job2.up   = held_v_r ? (held_r & col_mask) : '0;
    job2.mid  = in_row;
    job2.down = '0;
    job2.idx  = held_v_r ? cnt_inc : '0;
    job2.last = 1'b1;
  end

  // Accept a row when no flush is pending and the job register moves
  assign job_adv     = !job_v_r || res_ready;
  assign in_ch.ready = !pend_v_r && job_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Row window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r <= 1'b0;
      cnt_r    <= '0;
    end else if (in_xfer) begin
      if (in_ch.end_of_grid) begin
        held_v_r <= 1'b0;
        cnt_r    <= '0;
      end else begin
        held_v_r <= 1'b1;
        cnt_r    <= held_v_r ? cnt_inc : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r <= '0;
      held_r  <= '0;
    end else if (in_xfer) begin
      if (in_ch.end_of_grid) begin
        above_r <= '0;
        held_r  <= '0;
      end else begin
        above_r <= held_v_r ? held_r : '0;
        held_r  <= in_row;
      end
    end
  end

  // Job register and pending flush job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else if (job_adv) begin
      priority if (pend_v_r) begin
        job_v_r  <= 1'b1;
        pend_v_r <= 1'b0;
      end else if (in_xfer) begin
        job_v_r  <= held_v_r || in_ch.end_of_grid;
        pend_v_r <= held_v_r && in_ch.end_of_grid;
      end else begin
        job_v_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_adv) begin
      priority if (pend_v_r) begin
        job_r <= pend_r;
      end else if (in_xfer) begin
        job_r  <= held_v_r ? job1 : job2;
        pend_r <= job2;
      end
    end
  end

  // Pad the rows so the edge lanes see dead cells outside
  assign up_p   = {1'b0, job_r.up, 1'b0};
  assign mid_p  = {1'b0, job_r.mid, 1'b0};
  assign down_p = {1'b0, job_r.down, 1'b0};

  // Cell lanes
  for (genvar c = 0; c < W; c++) begin : g_lane
    lgrs_lane u_lane (
      .up_i    (up_p[c+2:c]),
      .side_i  ({mid_p[c+2], mid_p[c]}),
      .down_i  (down_p[c+2:c]),
      .alive_i (job_r.mid[c]),
      .rule_i  (rule_r),
      .live_o  (live[c])
    );
  end

  // Clip to the grid and mark changes
  assign next_row         = live & col_mask;
  assign res.next_cells   = lgrs_pkg::ROW_W'(next_row);
  assign res.changed_mask = lgrs_pkg::ROW_W'(next_row ^ job_r.mid);
  assign res.row_index    = job_r.idx;
  assign res.last_row     = job_r.last;

  lgrs_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid_i (job_v_r),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire

/* src/lgrs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgrs_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lgrs_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [lgrs_pkg::ROW_W-1:0]     out_changed_mask,
  input wire logic [lgrs_pkg::CNT_W-1:0]     out_changed_count
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Count tree agrees with the changed mask
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_changed_count) == $countones(out_changed_mask)))
    else $error("changed_count does not match changed_mask");

endmodule

bind life_generation_row_step_top lgrs_checker u_lgrs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_changed_mask  (out_ch.changed_mask),
  .out_changed_count (out_ch.changed_count)
);
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the life generation row step block. Rows stream in
// as valid/ready transfers. A local next-generation predictor forms the
// expected rows, and every result transfer is compared field by field against
// the oldest pending expectation. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import lgrs_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_CYC   = 7;
  localparam int DRAIN_CYC   = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [ROW_IDX_W-1:0] LAST_IDX = ROW_IDX_W'(DEF_MAX_ROWS - 1);

  typedef struct {
    logic [ROW_W-1:0]     next_cells;
    logic [ROW_W-1:0]     changed_mask;
    logic [CNT_W-1:0]     changed_count;
    logic [ROW_IDX_W-1:0] row_index;
    logic                 last_row;
  } gen_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  lgrs_in_if  in_ch ();
  lgrs_out_if out_ch ();

  life_generation_row_step_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor state and register copies
  logic [CFG_W-1:0]     width_reg = GRID_WIDTH_RESET;
  logic                 rule_reg = RULE_STANDARD;
  logic [ROW_W-1:0]     prev_row = '0;
  logic [ROW_W-1:0]     pend_row = '0;
  logic                 pend_valid = 1'b0;
  logic [ROW_IDX_W-1:0] pend_index = '0;

  gen_row_t expected_rows[$];
  int err_count = 0;
  int cycle_count = 0;
  int src_gap_pct = 0;
  int snk_stall_pct = 0;

  // Clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Drive inputs to known values from time zero
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.row_cells   = '0;
    in_ch.end_of_grid = 1'b0;
    out_ch.ready      = 1'b0;
  end

  // Receiver stall pattern
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("life_generation_row_step_top test failed");
      $finish;
    end
  end

  function automatic logic [ROW_W-1:0] col_mask();
    if (width_reg >= CFG_W'(ROW_W)) return '1;
    return (ROW_W'(1) << width_reg) - ROW_W'(1);
  endfunction

  // Next generation of one row from its two neighbor rows
  function automatic gen_row_t next_gen_row(logic [ROW_W-1:0] up, logic [ROW_W-1:0] mid,
                                            logic [ROW_W-1:0] down, logic last);
    logic [ROW_W-1:0] m;
    logic [ROW_W-1:0] nb [8];
    logic [ROW_W-1:0] nxt;
    logic live;
    int cnt;
    gen_row_t r;
    m = col_mask();
    up &= m;
    mid &= m;
    down &= m;
    nb[0] = up << 1;
    nb[1] = up;
    nb[2] = up >> 1;
    nb[3] = mid << 1;
    nb[4] = mid >> 1;
    nb[5] = down << 1;
    nb[6] = down;
    nb[7] = down >> 1;
    nxt = '0;
    for (int c = 0; c < ROW_W; c++) begin
      cnt = 0;
      for (int k = 0; k < 8; k++) cnt += int'(nb[k][c]);
      if (rule_reg == RULE_ALT) begin
        live = mid[c] || cnt == SURVIVE_LO;
      end else if (mid[c]) begin
        live = cnt == SURVIVE_LO || cnt == BIRTH_N;
      end else begin
        live = cnt == BIRTH_N;
      end
      nxt[c] = live;
    end
    nxt &= m;
    r.next_cells    = nxt;
    r.changed_mask  = (nxt ^ mid) & m;
    r.changed_count = CNT_W'($countones(r.changed_mask));
    r.row_index     = pend_index;
    r.last_row      = last;
    return r;
  endfunction

  // Advance the predictor by one accepted row
  function automatic void predict_row(logic [ROW_W-1:0] row, logic eog);
    row &= col_mask();
    if (pend_valid) begin
      expected_rows.push_back(next_gen_row(prev_row, pend_row, row, 1'b0));
      prev_row = pend_row;
      if (pend_index != LAST_IDX) pend_index++;
    end else begin
      prev_row   = '0;
      pend_index = '0;
    end
    pend_row   = row;
    pend_valid = 1'b1;
    if (eog) begin
      expected_rows.push_back(next_gen_row(prev_row, pend_row, '0, 1'b1));
      prev_row   = '0;
      pend_row   = '0;
      pend_valid = 1'b0;
      pend_index = '0;
    end
  endfunction

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    gen_row_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rows.size() == 0) begin
        $display("%0t ns: unexpected result: next_cells %h row_index %0d",
                 $time, out_ch.next_cells, out_ch.row_index);
        err_count++;
      end else begin
        e = expected_rows.pop_front();
        if (out_ch.next_cells !== e.next_cells) begin
          $display("%0t ns: next_cells expected %h, actual %h",
                   $time, e.next_cells, out_ch.next_cells);
          err_count++;
        end
        if (out_ch.changed_mask !== e.changed_mask) begin
          $display("%0t ns: changed_mask expected %h, actual %h",
                   $time, e.changed_mask, out_ch.changed_mask);
          err_count++;
        end
        if (out_ch.changed_count !== e.changed_count) begin
          $display("%0t ns: changed_count expected %0d, actual %0d",
                   $time, e.changed_count, out_ch.changed_count);
          err_count++;
        end
        if (out_ch.row_index !== e.row_index) begin
          $display("%0t ns: row_index expected %0d, actual %0d",
                   $time, e.row_index, out_ch.row_index);
          err_count++;
        end
        if (out_ch.last_row !== e.last_row) begin
          $display("%0t ns: last_row expected %b, actual %b",
                   $time, e.last_row, out_ch.last_row);
          err_count++;
        end
      end
    end
  end

  // Send one row; called and returns at a falling edge, valid left high
  task automatic send_row(logic [ROW_W-1:0] row, logic eog);
    while ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.row_cells   <= row;
    in_ch.end_of_grid <= eog;
    do @(posedge clk); while (!in_ch.ready);
    predict_row(row, eog);
    @(negedge clk);
  endtask

  // Hold the input and wait until the block has nothing left in flight
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  // Register write; the block must be idle
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == REG_GRID_WIDTH) width_reg = val;
    else if (idx == REG_RULE_MODE) rule_reg = val[0];
  endtask

  task automatic set_config(logic [CFG_W-1:0] w, logic rule);
    drain();
    cfg_write(REG_GRID_WIDTH, w);
    cfg_write(REG_RULE_MODE, CFG_W'(rule));
  endtask

  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return a;
      1: return a & b;
      2: return a | b;
      default: return a & b & c;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_width();
    case ($urandom_range(9))
      0, 1, 2, 3: return CFG_W'(ROW_W);
      4, 5:       return CFG_W'($urandom_range(ROW_W, 1));
      6, 7:       return CFG_W'($urandom_range(8, 1));
      8:          return CFG_W'($urandom_range(127, ROW_W + 1));
      default:    return CFG_W'($urandom_range(1) ? 0 : 63);
    endcase
  endfunction

  // Reset defaults: single-row grids and a plain three-row grid
  task automatic test_defaults();
    send_row('0, 1'b1);
    send_row('1, 1'b1);
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
  endtask

  // Blinker, block and edge columns under the standard rule
  task automatic test_patterns();
    send_row(64'h0000_0000_0000_0010, 1'b0);
    send_row(64'h0000_0000_0000_0010, 1'b0);
    send_row(64'h0000_0000_0000_0010, 1'b1);
    send_row(64'h8000_0000_0000_0003, 1'b0);
    send_row(64'hC000_0000_0000_0003, 1'b0);
    send_row(64'h4000_0000_0000_0001, 1'b1);
  endtask

  // Alternate rule: keep alive or born on exactly two
  task automatic test_alt_rule();
    set_config(CFG_W'(ROW_W), RULE_ALT);
    send_row(64'h0000_0000_0000_0005, 1'b0);
    send_row(64'h8000_0000_0000_0000, 1'b0);
    send_row(64'hAAAA_5555_AAAA_5555, 1'b1);
  endtask

  // Width extremes, zero width, width above range, bits beyond the width
  task automatic test_width_edges();
    set_config(CFG_W'(1), RULE_STANDARD);
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    set_config(CFG_W'(5), RULE_STANDARD);
    send_row(64'hFFFF_FFFF_FFFF_FFE0, 1'b0);
    send_row('1, 1'b1);
    set_config(CFG_W'(0), RULE_ALT);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    set_config(CFG_W'(127), RULE_STANDARD);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row('1, 1'b1);
  endtask

  // Width changed while rows are held in the middle of a grid
  task automatic test_width_mid_grid();
    set_config(CFG_W'(ROW_W), RULE_STANDARD);
    send_row('1, 1'b0);
    send_row(64'hF0F0_F0F0_F0F0_F0F0, 1'b0);
    drain();
    cfg_write(REG_GRID_WIDTH, CFG_W'(12));
    send_row('1, 1'b1);
    set_config(CFG_W'(ROW_W), RULE_STANDARD);
  endtask

  // Random grids with random registers between them
  task automatic test_random_grids(int n_items);
    int sent;
    int height;
    int mid_at;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) set_config(rand_width(), $urandom_range(1));
      height = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(10, 1);
      mid_at = ($urandom_range(9) == 0) ? $urandom_range(height - 1, 0) : -1;
      for (int r = 0; r < height; r++) begin
        if (r == mid_at && r != 0) begin
          drain();
          cfg_write(REG_GRID_WIDTH, rand_width());
        end
        send_row(rand_row(), r == height - 1);
        sent++;
      end
    end
  endtask

  // Grid taller than the row counter, so row_index saturates
  task automatic test_tall_grid();
    set_config(CFG_W'(ROW_W), $urandom_range(1));
    for (int r = 0; r < DEF_MAX_ROWS + 6; r++) send_row(rand_row(), r == DEF_MAX_ROWS + 5);
  endtask

  initial begin
    repeat (RESET_CYC) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase one: sender idles a little, receiver stalls often
    src_gap_pct   = 8;
    snk_stall_pct = 57;
    test_defaults();
    test_patterns();
    test_alt_rule();
    test_width_edges();
    test_width_mid_grid();
    test_random_grids(300);

    // Phase two: sender idles often, receiver stalls a little
    src_gap_pct   = 57;
    snk_stall_pct = 8;
    test_random_grids(300);

    // Phase three: full rate on both sides
    src_gap_pct   = 0;
    snk_stall_pct = 0;
    test_tall_grid();
    test_random_grids(200);

    drain();
    repeat (4 * DRAIN_CYC) @(negedge clk);
    if (err_count == 0 && expected_rows.size() == 0) begin
      $display("life_generation_row_step_top test passed");
    end else begin
      $display("life_generation_row_step_top test failed");
    end
    $finish;
  end

endmodule

/* life_generation_row_step_top.f */
src/lgrs_pkg.sv
src/lgrs_if.sv
src/lgrs_lane.sv
src/lgrs_merge.sv
src/life_generation_row_step_top.sv
src/lgrs_checker.sv
sim/tb_top.sv
